// ----- src/sorted_insertion_store_unit_macros.svh -----
// ---------------------------------------------------------------------------
// Sorted insertion store: assertion macros
// Shared concurrent assertion forms, sampled on clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef SORTED_INSERTION_STORE_UNIT_MACROS_SVH
`define SORTED_INSERTION_STORE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SIS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SIS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/sis_pkg.sv -----
// ---------------------------------------------------------------------------
// Sorted insertion store: package
// Operation and status codes, cell commands and the result record.
// ---------------------------------------------------------------------------
package sis_pkg;

	// Default number of cells in the chain.
	localparam int SIS_DEPTH = 16;

	localparam int DATA_W = 32;
	localparam int POS_W  = 6;

	// Operation codes of a request transaction.
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;
	localparam logic [1:0] OP_READ   = 2'd3;

	// Status codes of a response transaction.
	localparam logic [1:0] STS_DONE  = 2'd0;
	localparam logic [1:0] STS_ENTRY = 2'd1;
	localparam logic [1:0] STS_FULL  = 2'd2;
	localparam logic [1:0] STS_EMPTY = 2'd3;

	// Commands broadcast to every cell of the chain.
	localparam logic [1:0] ACT_HOLD   = 2'd0;
	localparam logic [1:0] ACT_INSERT = 2'd1;
	localparam logic [1:0] ACT_REMOVE = 2'd2;
	localparam logic [1:0] ACT_ROTATE = 2'd3;

	typedef struct packed {
		logic [1:0]               act;
		logic signed [DATA_W-1:0] key;
	} cell_ctl_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] entry_value;
		logic [POS_W-1:0]         position;
		logic [1:0]               status;
		logic                     last;
	} result_t;

endpackage

// ----- src/sis_req_if.sv -----
// ---------------------------------------------------------------------------
// Sorted insertion store: request channel
// Valid/ready channel carrying an operation and its value.
// ---------------------------------------------------------------------------
interface sis_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         op;
	logic signed [31:0] value;

	modport source (output valid, op, value, input ready);
	modport sink (input valid, op, value, output ready);
endinterface

// ----- src/sis_rsp_if.sv -----
// ---------------------------------------------------------------------------
// Sorted insertion store: response channel
// Valid/ready channel carrying one result of an operation.
// ---------------------------------------------------------------------------
interface sis_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] entry_value;
	logic [5:0]         position;
	logic [1:0]         status;
	logic               last;

	modport source (output valid, entry_value, position, status, last, input ready);
	modport sink (input valid, entry_value, position, status, last, output ready);
endinterface

// ----- src/sis_cell.sv -----
// ---------------------------------------------------------------------------
// Sorted insertion store: storage cell
// Holds one entry and takes a new one from itself, the key, a neighbour or the head cell.
// ---------------------------------------------------------------------------
module sis_cell
	import sis_pkg::*;
(
	input  logic                     clk,
	input  cell_ctl_t                ctl,
	input  logic                     occ,
	input  logic                     tail,
	input  logic                     prev_lt,
	input  logic signed [DATA_W-1:0] prev_data,
	input  logic signed [DATA_W-1:0] next_data,
	input  logic signed [DATA_W-1:0] head_data,
	output logic signed [DATA_W-1:0] data,
	output logic                     lt,
	output logic                     match
);

	logic signed [DATA_W-1:0] data_q;
	logic signed [DATA_W-1:0] data_d;

	// Compare the held entry with the broadcast key.
	assign lt    = occ && (data_q < ctl.key);
	assign match = occ && (data_q == ctl.key);
	assign data  = data_q;

	// Select the next content of the cell.
	always_comb begin
		data_d = data_q;
		unique case (ctl.act)
			ACT_HOLD: begin
				data_d = data_q;
			end
			ACT_INSERT: begin
				if (!lt) begin
					data_d = prev_lt ? ctl.key : prev_data;
				end
			end
			ACT_REMOVE: begin
				if (occ && !lt) begin
					data_d = next_data;
				end
			end
			ACT_ROTATE: begin
				data_d = tail ? head_data : next_data;
			end
			default: begin
				data_d = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

endmodule

// ----- src/sis_result_fifo.sv -----
// ---------------------------------------------------------------------------
// Sorted insertion store: result queue
// Two-slot queue that decouples result production from the response channel.
// ---------------------------------------------------------------------------
module sis_result_fifo
	import sis_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    full,
	input  logic    pop,
	output logic    head_valid,
	output result_t head_data
);

	result_t    slot_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign full       = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head_data  = slot_q[rptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wptr_q <= ~wptr_q;
			end
			if (do_pop) begin
				rptr_q <= ~rptr_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// Slot contents.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wptr_q] <= push_data;
		end
	end

endmodule

// ----- src/sorted_insertion_store_unit.sv -----
// ---------------------------------------------------------------------------
// Sorted insertion store unit
// Ascending store of signed words built as a chain of cells, with a sequencer.
// ---------------------------------------------------------------------------
// The store holds up to DEPTH signed 32-bit entries in ascending order, one per
// cell. Insert, clear and every error case give one result in the cycle that
// takes the request. Delete takes the request, then closes one gap per removed
// entry (all cells above the match shift down by one), and at last finds no
// match left and gives the result. Read out takes the request and then rotates
// the chain once per result, which leaves the store in its original order. A
// request is taken only while no operation is in progress and the result buffer
// is not full; results queue in a two-slot buffer, so a waiting response does
// not hold the chain until that is full, and while the buffer stays full it
// stalls read out and the end of a delete.
// ---------------------------------------------------------------------------
`include "sorted_insertion_store_unit_macros.svh"

module sorted_insertion_store_unit
	import sis_pkg::*;
#(
	parameter int DEPTH = SIS_DEPTH
) (
	input logic       clk,
	input logic       arst_n,
	sis_req_if.sink   req,
	sis_rsp_if.source rsp
);

	localparam int CW = $clog2(DEPTH + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DEL  = 2'd1;
	localparam logic [1:0] ST_READ = 2'd2;

	logic [1:0]               state_q;
	logic [1:0]               state_d;
	logic [CW-1:0]            count_q;
	logic [CW-1:0]            count_d;
	logic [CW-1:0]            idx_q;
	logic [CW-1:0]            idx_d;
	logic [CW-1:0]            cnt_m1;
	logic signed [DATA_W-1:0] key_q;
	logic                     accept;
	logic                     fifo_full;
	logic                     push;
	result_t                  push_data;
	result_t                  head_data;
	logic                     any_match;
	cell_ctl_t                ctl;

	logic signed [DATA_W-1:0] cell_data [DEPTH];
	logic [DEPTH-1:0]         cell_lt;
	logic [DEPTH-1:0]         cell_match;

	assign cnt_m1     = count_q - CW'(1);
	assign any_match  = |cell_match;
	assign req.ready  = (state_q == ST_IDLE) && !fifo_full;
	assign accept     = req.valid && req.ready;

	// Chain of cells, each fed by its neighbours and the head entry.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                     prev_lt;
		logic signed [DATA_W-1:0] prev_data;
		logic signed [DATA_W-1:0] next_data;

		if (i == 0) begin : g_head
			assign prev_lt   = 1'b1;
			assign prev_data = '0;
		end else begin : g_body
			assign prev_lt   = cell_lt[i-1];
			assign prev_data = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_end
			assign next_data = '0;
		end else begin : g_mid
			assign next_data = cell_data[i+1];
		end

		sis_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occ       (CW'(i) < count_q),
			.tail      (CW'(i) == cnt_m1),
			.prev_lt   (prev_lt),
			.prev_data (prev_data),
			.next_data (next_data),
			.head_data (cell_data[0]),
			.data      (cell_data[i]),
			.lt        (cell_lt[i]),
			.match     (cell_match[i])
		);
	end

	// Sequencer: decodes requests, drives the chain and produces results.
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		ctl.act   = ACT_HOLD;
		ctl.key   = key_q;
		push      = 1'b0;
		push_data = '0;
		push_data.last = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				ctl.key = req.value;
				if (accept) begin
					unique case (req.op)
						OP_INSERT: begin
							push = 1'b1;
							if (count_q == CW'(DEPTH)) begin
								push_data.status = STS_FULL;
							end else begin
								ctl.act          = ACT_INSERT;
								count_d          = count_q + CW'(1);
								push_data.status = STS_DONE;
							end
						end
						OP_DELETE: begin
							if (count_q == '0) begin
								push             = 1'b1;
								push_data.status = STS_EMPTY;
							end else begin
								state_d = ST_DEL;
							end
						end
						OP_CLEAR: begin
							count_d          = '0;
							push             = 1'b1;
							push_data.status = STS_DONE;
						end
						OP_READ: begin
							if (count_q == '0) begin
								push             = 1'b1;
								push_data.status = STS_EMPTY;
							end else begin
								idx_d   = '0;
								state_d = ST_READ;
							end
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_DEL: begin
				if (any_match) begin
					ctl.act = ACT_REMOVE;
					count_d = cnt_m1;
				end else if (!fifo_full) begin
					push             = 1'b1;
					push_data.status = STS_DONE;
					state_d          = ST_IDLE;
				end
			end
			ST_READ: begin
				if (!fifo_full) begin
					push                  = 1'b1;
					push_data.entry_value = cell_data[0];
					push_data.position    = POS_W'(idx_q);
					push_data.status      = STS_ENTRY;
					push_data.last        = (idx_q == cnt_m1);
					ctl.act               = ACT_ROTATE;
					idx_d                 = idx_q + CW'(1);
					if (idx_q == cnt_m1) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			idx_q   <= idx_d;
		end
	end

	// The delete key is held for the whole compaction.
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= req.value;
		end
	end

	sis_result_fifo u_result_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (fifo_full),
		.pop        (rsp.ready),
		.head_valid (rsp.valid),
		.head_data  (head_data)
	);

	assign rsp.entry_value = head_data.entry_value;
	assign rsp.position    = head_data.position;
	assign rsp.status      = head_data.status;
	assign rsp.last        = head_data.last;

	// Checks on the sequencer and the fill count.
	`SIS_ASSERT_SAME(a_count_bound, 1'b1, count_q <= CW'(DEPTH), "fill count above depth")
	`SIS_ASSERT_NEXT(a_remove_dec, (state_q == ST_DEL) && any_match,
		count_q == CW'($past(count_q) - CW'(1)), "removal did not shrink the store")
	`SIS_ASSERT_NEXT(a_read_end, (state_q == ST_READ) && push && push_data.last,
		state_q == ST_IDLE, "read out did not end on its last entry")
	`SIS_ASSERT_NEXT(a_del_end, (state_q == ST_DEL) && !any_match && !fifo_full,
		state_q == ST_IDLE, "delete did not finish once no match remained")

endmodule

// ----- test/tb_sorted_insertion_store_unit.sv -----
// ---------------------------------------------------------------------------
// Sorted insertion store unit: testbench
// Drives insert, delete, clear and read-out requests through the request
// channel. Every accepted request is applied to a local copy of the sorted
// store, which gives the responses to expect. Each response transaction is
// then compared field by field with the oldest one still awaited.
// ---------------------------------------------------------------------------
module tb_sorted_insertion_store_unit;
	import sis_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH       = SIS_DEPTH;
	localparam int HOLD_CYCLES = 300;
	localparam int IDLE_LIMIT  = 2000;
	localparam int TAIL_CYCLES = 40;
	localparam int RANDOM_OPS  = 230;

	localparam logic signed [31:0] MAX_VAL = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] MIN_VAL = 32'sh8000_0000;

	// One row of the directed stimulus table.
	typedef struct {
		logic [1:0]         op;
		logic signed [31:0] val;
		bit                 typed;
		logic [1:0]         status;
	} stim_row_t;

	logic clk;
	logic arst_n;

	sis_req_if req_ch ();
	sis_rsp_if rsp_ch ();

	sorted_insertion_store_unit #(
		.DEPTH(DEPTH)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// Local image of the store, kept in ascending order.
	logic signed [31:0] store_image[$];
	// Responses awaited, oldest first.
	result_t            awaited[$];
	stim_row_t          stim_table[$];

	int fail_count;
	int idle_cycles;
	bit quiet;
	bit hold_rsp;
	int low_left;

	// Clock with a 10 ns period.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Gap lengths: mostly short, now and then long.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Applies one operation to the store image and gives the responses it causes.
	function automatic void apply_op(input logic [1:0] op, input logic signed [31:0] val,
			output result_t outs[$]);
		result_t r;
		int      i;
		outs = {};
		r = '{entry_value: '0, position: '0, status: STS_DONE, last: 1'b1};
		case (op)
			OP_INSERT: begin
				if (store_image.size() >= DEPTH) begin
					r.status = STS_FULL;
				end else begin
					i = 0;
					while (i < store_image.size() && store_image[i] < val)
						i++;
					store_image.insert(i, val);
				end
				outs.push_back(r);
			end
			OP_DELETE: begin
				if (store_image.size() == 0) begin
					r.status = STS_EMPTY;
				end else begin
					for (i = store_image.size() - 1; i >= 0; i--)
						if (store_image[i] == val)
							store_image.delete(i);
				end
				outs.push_back(r);
			end
			OP_CLEAR: begin
				store_image = {};
				outs.push_back(r);
			end
			default: begin
				if (store_image.size() == 0) begin
					r.status = STS_EMPTY;
					outs.push_back(r);
				end else begin
					foreach (store_image[k]) begin
						r.entry_value = store_image[k];
						r.position    = k[5:0];
						r.status      = STS_ENTRY;
						r.last        = (k == store_image.size() - 1);
						outs.push_back(r);
					end
				end
			end
		endcase
	endfunction

	// Values biased towards extremes, small numbers and entries already stored.
	function automatic logic signed [31:0] pick_value(input int reuse_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < reuse_pct && store_image.size() != 0)
			return store_image[$urandom_range(0, store_image.size() - 1)];
		r = $urandom_range(0, 9);
		case (r)
			0: return MAX_VAL;
			1: return MIN_VAL;
			2, 3, 4: return $signed($urandom_range(0, 8)) - 4;
			default: return $urandom;
		endcase
	endfunction

	// Offers one request transaction and records what it should produce.
	task automatic offer(input logic [1:0] op, input logic signed [31:0] val,
			input bit typed, input logic [1:0] status);
		int      gap;
		result_t outs[$];
		gap = (quiet || $urandom_range(0, 1) == 0) ? 0 : gap_len();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op    <= op;
		req_ch.value <= val;
		do
			@(posedge clk);
		while (!req_ch.ready);
		apply_op(op, val, outs);
		if (typed)
			awaited.push_back('{entry_value: '0, position: '0, status: status, last: 1'b1});
		else
			foreach (outs[k])
				awaited.push_back(outs[k]);
		@(negedge clk);
	endtask

	// Stops offering until every awaited response has arrived.
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (awaited.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic add_row(input logic [1:0] op, input logic signed [31:0] val,
			input bit typed, input logic [1:0] status);
		stim_table.push_back('{op: op, val: val, typed: typed, status: status});
	endtask

	// Response side: random stalls, a long hold-off on request, none when quiet.
	initial begin
		low_left = 0;
		forever begin
			@(negedge clk);
			if (hold_rsp) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_rsp = 1'b0;
			end else if (quiet) begin
				rsp_ch.ready <= 1'b1;
				low_left = 0;
			end else if (low_left > 0) begin
				rsp_ch.ready <= 1'b0;
				low_left--;
			end else begin
				rsp_ch.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					low_left = gap_len();
			end
		end
	end

	// Compare each response transaction with the oldest awaited one.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (awaited.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected response value=%0d pos=%0d status=%0d last=%0b",
					$realtime, rsp_ch.entry_value, rsp_ch.position, rsp_ch.status,
					rsp_ch.last);
			end else begin
				want = awaited.pop_front();
				if (rsp_ch.entry_value !== want.entry_value) begin
					fail_count++;
					$display("%0t: entry_value expected %0d, got %0d", $realtime,
						want.entry_value, rsp_ch.entry_value);
				end
				if (rsp_ch.position !== want.position) begin
					fail_count++;
					$display("%0t: position expected %0d, got %0d", $realtime,
						want.position, rsp_ch.position);
				end
				if (rsp_ch.status !== want.status) begin
					fail_count++;
					$display("%0t: status expected %0d, got %0d", $realtime,
						want.status, rsp_ch.status);
				end
				if (rsp_ch.last !== want.last) begin
					fail_count++;
					$display("%0t: last expected %0b, got %0b", $realtime,
						want.last, rsp_ch.last);
				end
			end
		end
	end

	// Watchdog: ends the run when nothing has been accepted for too long.
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $realtime, IDLE_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Main sequence: reset, directed table, back-pressure phase, random mix.
	initial begin
		int r;
		fail_count   = 0;
		idle_cycles  = 0;
		quiet        = 1'b0;
		hold_rsp     = 1'b0;
		arst_n       = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.op    = OP_INSERT;
		req_ch.value = '0;
		rsp_ch.ready = 1'b0;

		// Empty store cases, extremes, duplicates, deletes at head, tail and nowhere.
		add_row(OP_READ,   0,            1, STS_EMPTY);
		add_row(OP_DELETE, 0,            1, STS_EMPTY);
		add_row(OP_CLEAR,  0,            1, STS_DONE);
		add_row(OP_INSERT, MAX_VAL,      1, STS_DONE);
		add_row(OP_INSERT, MIN_VAL,      1, STS_DONE);
		add_row(OP_INSERT, 0,            1, STS_DONE);
		add_row(OP_INSERT, -1,           1, STS_DONE);
		add_row(OP_INSERT, 0,            1, STS_DONE);
		add_row(OP_INSERT, 1,            1, STS_DONE);
		add_row(OP_READ,   0,            0, STS_DONE);
		add_row(OP_DELETE, 0,            1, STS_DONE);
		add_row(OP_DELETE, 5,            1, STS_DONE);
		add_row(OP_DELETE, MIN_VAL,      1, STS_DONE);
		add_row(OP_DELETE, MAX_VAL,      1, STS_DONE);
		add_row(OP_READ,   0,            0, STS_DONE);
		add_row(OP_INSERT, 32'h5555_5555, 1, STS_DONE);
		add_row(OP_INSERT, 32'hAAAA_AAAA, 1, STS_DONE);
		add_row(OP_READ,   32'hFFFF_FFFF, 0, STS_DONE);
		add_row(OP_CLEAR,  32'h1234_5678, 1, STS_DONE);
		add_row(OP_READ,   0,            1, STS_EMPTY);
		add_row(OP_DELETE, 7,            1, STS_EMPTY);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (stim_table[k])
			offer(stim_table[k].op, stim_table[k].val, stim_table[k].typed,
				stim_table[k].status);
		drain();

		// Fill past capacity and read out while responses are held off.
		offer(OP_CLEAR, 0, 0, STS_DONE);
		hold_rsp = 1'b1;
		for (int k = 0; k < DEPTH + 2; k++)
			offer(OP_INSERT, pick_value(10), 0, STS_DONE);
		repeat (3)
			offer(OP_READ, 0, 0, STS_DONE);
		drain();

		// Random mix, with stretches free of idling and the odd full pause.
		for (int k = 0; k < RANDOM_OPS; k++) begin
			quiet = (k >= 60 && k < 90) || (k >= 150 && k < 180);
			r = $urandom_range(0, 99);
			if (r < 45)
				offer(OP_INSERT, pick_value(20), 0, STS_DONE);
			else if (r < 65)
				offer(OP_DELETE, pick_value(50), 0, STS_DONE);
			else if (r < 70)
				offer(OP_CLEAR, $urandom, 0, STS_DONE);
			else
				offer(OP_READ, $urandom, 0, STS_DONE);
			if (!quiet && $urandom_range(0, 49) == 0)
				drain();
		end
		quiet = 1'b0;
		drain();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
